// ===== rtl/dpsc_pkg.sv =====
// ============================================================================
// dpsc_pkg - drive power state controller shared definitions
// Drive state codes, status decode patterns and command pattern tables.
// ============================================================================
package dpsc_pkg;

  typedef enum logic [2:0] {
    ST_NOT_READY      = 3'd0,
    ST_DISABLED       = 3'd1,
    ST_READY          = 3'd2,
    ST_SWITCHED_ON    = 3'd3,
    ST_ENABLED        = 3'd4,
    ST_QUICK_STOP     = 3'd5,
    ST_FAULT_REACTION = 3'd6,
    ST_FAULT          = 3'd7
  } drive_state_t;

  localparam int NUM_PATTERNS = 8;
  localparam int NUM_STATES   = 8;

  // Command pattern: bits under mask take value, others keep the held word.
  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] value;
    logic        present;
  } cmd_t;

  // Result of the command select and merge.
  typedef struct packed {
    logic [15:0] control;
    logic        error;
  } merge_res_t;

  localparam logic [7:0] MODE_RESET = 8'd8;

  // Status decode patterns, tried in order; first match wins.
  localparam logic [15:0] DEC_MASK [NUM_PATTERNS] = '{
    16'h004f, 16'h006f, 16'h006f, 16'h006f,
    16'h006f, 16'h004f, 16'h004f, 16'h004f
  };
  localparam logic [15:0] DEC_VALUE [NUM_PATTERNS] = '{
    16'h0040, 16'h0021, 16'h0023, 16'h0027,
    16'h0007, 16'h000f, 16'h0008, 16'h0000
  };
  localparam drive_state_t DEC_STATE [NUM_PATTERNS] = '{
    ST_DISABLED, ST_READY, ST_SWITCHED_ON, ST_ENABLED,
    ST_QUICK_STOP, ST_FAULT_REACTION, ST_FAULT, ST_NOT_READY
  };

  // Combined masks: 0x81|0x06, 0x88|0x07 (also 0x80|0x0F etc.), 0x80|0x02, 0x80|0x08.
  localparam logic [15:0] MASK_SHUTDOWN = 16'h0087;
  localparam logic [15:0] MASK_FULL     = 16'h008F;
  localparam logic [15:0] MASK_QS_HOLD  = 16'h0082;
  localparam logic [15:0] MASK_FLT      = 16'h0088;
  localparam logic [15:0] MASK_RESET    = 16'h0080;

  // Tables indexed by drive state.
  localparam cmd_t ENABLE_CMD [NUM_STATES] = '{
    '{MASK_SHUTDOWN, 16'h0006, 1'b1},
    '{MASK_SHUTDOWN, 16'h0006, 1'b1},
    '{MASK_FULL,     16'h0007, 1'b1},
    '{MASK_FULL,     16'h000F, 1'b1},
    '{16'h0000,      16'h0000, 1'b1},
    '{MASK_FULL,     16'h000B, 1'b1},
    '{MASK_RESET,    16'h0080, 1'b1},
    '{MASK_RESET,    16'h0080, 1'b1}
  };

  localparam cmd_t DISABLE_CMD [NUM_STATES] = '{
    '{MASK_SHUTDOWN, 16'h0000, 1'b1},
    '{MASK_SHUTDOWN, 16'h0000, 1'b1},
    '{MASK_FULL,     16'h0000, 1'b1},
    '{MASK_FULL,     16'h0006, 1'b1},
    '{MASK_FULL,     16'h0007, 1'b1},
    '{16'h0000,      16'h0000, 1'b0},
    '{MASK_FULL,     16'h0080, 1'b1},
    '{MASK_FLT,      16'h0080, 1'b1}
  };

  localparam cmd_t QUICK_CMD [NUM_STATES] = '{
    '{16'h0000,      16'h0000, 1'b0},
    '{MASK_SHUTDOWN, 16'h0000, 1'b1},
    '{16'h0000,      16'h0000, 1'b0},
    '{16'h0000,      16'h0000, 1'b0},
    '{MASK_FULL,     16'h0002, 1'b1},
    '{MASK_QS_HOLD,  16'h0000, 1'b1},
    '{16'h0000,      16'h0000, 1'b0},
    '{16'h0000,      16'h0000, 1'b0}
  };

endpackage

// ===== rtl/dpsc_status_decode.sv =====
// ============================================================================
// dpsc_status_decode - status word to drive state
// Masked-compare decode of the status word; no match decodes as fault.
// ============================================================================
module dpsc_status_decode (
  input  logic [15:0]           status,
  output dpsc_pkg::drive_state_t state
);

  always_comb begin
    state = dpsc_pkg::ST_FAULT;
    // Scan from the last pattern down so the first match wins.
    for (int i = dpsc_pkg::NUM_PATTERNS - 1; i >= 0; i--) begin
      if ((status & dpsc_pkg::DEC_MASK[i]) == dpsc_pkg::DEC_VALUE[i]) begin
        state = dpsc_pkg::DEC_STATE[i];
      end
    end
  end

endmodule

// ===== rtl/dpsc_command_merge.sv =====
// ============================================================================
// dpsc_command_merge - command select and control word merge
// Pick the command pattern for state and request, merge into the held word.
// ============================================================================
module dpsc_command_merge (
  input  dpsc_pkg::drive_state_t state,
  input  logic                   enable_request,
  input  logic                   quick_stop_request,
  input  logic [15:0]            held_control,
  output dpsc_pkg::merge_res_t   result
);

  dpsc_pkg::cmd_t cmd;

  always_comb begin
    priority if (quick_stop_request) begin
      cmd = dpsc_pkg::QUICK_CMD[state];
    end else if (enable_request) begin
      cmd = dpsc_pkg::ENABLE_CMD[state];
    end else begin
      cmd = dpsc_pkg::DISABLE_CMD[state];
    end
  end

  always_comb begin
    result.error = !cmd.present;
    if (cmd.present) begin
      result.control = (held_control & ~cmd.mask) | (cmd.value & cmd.mask);
    end else begin
      result.control = held_control;
    end
  end

endmodule

// ===== rtl/drive_power_state_controller.sv =====
// ============================================================================
// drive_power_state_controller - CiA 402 style drive power state controller
// Decodes the drive status word each bus cycle and produces the merged
// control word, mode and target writes, and state flags.
// ============================================================================
// One status transfer enters per clock while s_axis_tready is high: the input
// register holds the item, the decode and the masked merge run between it and
// the result register, and the held control word, previous-enabled flag and
// recorded state update in the cycle an item moves into the result register.
// Sustained rate is one item per cycle; a stalled result register backs up
// into the input register and then into tready.
//
// s_axis_tdata fields, lowest bit up: drive_status[15:0], enable_request[16],
// quick_stop_request[17], actual_position[49:18], zero fill [55:50].
// m_axis_tdata fields, lowest bit up: control_out[15:0], mode_write[16],
// mode_value[24:17], target_write[25], target_pos[57:26],
// command_error[58], drive_state[61:59], state_changed[62], is_enabled[63].
// cfg_data sets operation_mode (signed, reset 8); write while idle, not enforced.
// ============================================================================
module drive_power_state_controller (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // drive_status, enable_request,
                                      // quick_stop_request, actual_position
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // control_out, mode_write, mode_value,
                                      // target_write, target_pos,
                                      // command_error, drive_state,
                                      // state_changed, is_enabled
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // operation_mode
);

  // Configuration register
  logic signed [7:0] operation_mode;

  // Input register
  logic               in_valid;
  logic [15:0]        in_status;
  logic               in_enable;
  logic               in_quick;
  logic signed [31:0] in_position;

  // Running state
  logic [15:0]            held_control;
  logic                   was_enabled;
  dpsc_pkg::drive_state_t recorded_state;

  // Result register
  logic               out_valid;
  logic [15:0]        out_control;
  logic               out_mode_write;
  logic signed [7:0]  out_mode_value;
  logic               out_target_write;
  logic signed [31:0] out_target_pos;
  logic               out_error;
  logic [2:0]         out_state;
  logic               out_changed;
  logic               out_enabled;

  // Per-item combinational results
  dpsc_pkg::drive_state_t state;
  dpsc_pkg::merge_res_t   merge;
  logic                   advance;
  logic                   in_accept;
  logic                   mode_write_next;
  logic                   enabled_next;
  logic                   changed_next;

  // Move the held item into the result register when that register is free
  // or its result is being taken this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  dpsc_status_decode u_decode (
    .status (in_status),
    .state  (state)
  );

  dpsc_command_merge u_merge (
    .state              (state),
    .enable_request     (in_enable),
    .quick_stop_request (in_quick),
    .held_control       (held_control),
    .result             (merge)
  );

  // Mode goes out only in the switched-on state and only when a command was
  // found.
  assign mode_write_next = !merge.error && (state == dpsc_pkg::ST_SWITCHED_ON);
  assign enabled_next    = (state == dpsc_pkg::ST_ENABLED);
  assign changed_next    = (state != recorded_state);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      operation_mode <= dpsc_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      operation_mode <= cfg_data;
    end
  end

  // Input register: load on transfer, drop when the item advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_status   <= s_axis_tdata[15:0];
      in_enable   <= s_axis_tdata[16];
      in_quick    <= s_axis_tdata[17];
      in_position <= s_axis_tdata[49:18];
    end
  end

  // Running state advances with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_control   <= 16'h0000;
      was_enabled    <= 1'b0;
      recorded_state <= dpsc_pkg::ST_NOT_READY;
    end else if (advance) begin
      held_control   <= merge.control;
      was_enabled    <= enabled_next;
      recorded_state <= state;
    end
  end

  // Result register: fill on advance, empty once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_control      <= merge.control;
      out_mode_write   <= mode_write_next;
      out_mode_value   <= mode_write_next ? operation_mode : 8'sd0;
      // Track actual position while the drive was not enabled at the previous item.
      out_target_write <= !was_enabled;
      out_target_pos   <= was_enabled ? 32'sd0 : in_position;
      out_error        <= merge.error;
      out_state        <= state;
      out_changed      <= changed_next;
      out_enabled      <= enabled_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_enabled, out_changed, out_state, out_error,
                          out_target_pos, out_target_write,
                          out_mode_value, out_mode_write, out_control};

endmodule
